FILE: src/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types, codes and reset values of the dispenser motor controller.
// ----------------------------------------------------------------------------
package dmc_pkg;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	typedef enum logic [1:0] {
		CMD_TICK     = 2'd0,
		CMD_DISPENSE = 2'd1,
		CMD_QUERY    = 2'd2,
		CMD_LOAD     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_LOW     = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_BLOCKED = 3'd3,
		ST_READY   = 3'd4,
		ST_NOTDISP = 3'd5,
		ST_WORKING = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_WAIT  = 3'b010,
		PH_EXTRA = 3'b100
	} phase_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_RELAY_INV   = 3'd0,
		CFG_LOW_THRESH  = 3'd1,
		CFG_MOTOR_TMO   = 3'd2,
		CFG_REMOVE_TMO  = 3'd3,
		CFG_EXTRA_RUN   = 3'd4,
		CFG_MAX_RETRIES = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic        relay_inverted;
		logic [7:0]  low_level_threshold;
		logic [15:0] motor_timeout_ms;
		logic [15:0] remove_timeout_ms;
		logic [15:0] extra_run_ms;
		logic [3:0]  max_retries;
	} cfg_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       empty_sensor;
		logic       exit_sensor;
		logic [7:0] stock_value;
	} item_t;

	typedef struct packed {
		logic       motor_drive;
		logic [2:0] status;
		logic [7:0] stock_count;
		logic       busy_res;
	} result_t;

	localparam logic        RST_RELAY_INV   = 1'b0;
	localparam logic [7:0]  RST_LOW_THRESH  = 8'd5;
	localparam logic [15:0] RST_MOTOR_TMO   = 16'd3000;
	localparam logic [15:0] RST_REMOVE_TMO  = 16'd30000;
	localparam logic [15:0] RST_EXTRA_RUN   = 16'd4000;
	localparam logic [3:0]  RST_MAX_RETRIES = 4'd3;

	localparam logic [15:0] SINCE_SAT = 16'hFFFF;

endpackage

FILE: src/dmc_if.sv
// ----------------------------------------------------------------------------
// dmc channel interfaces
// Valid/ready channels for tick items, results and register writes.
// ----------------------------------------------------------------------------
interface dmc_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic       empty_sensor;
	logic       exit_sensor;
	logic [7:0] stock_value;

	modport source (output valid, cmd, empty_sensor, exit_sensor, stock_value, input ready);
	modport sink   (input valid, cmd, empty_sensor, exit_sensor, stock_value, output ready);
endinterface

interface dmc_result_if;
	logic       valid;
	logic       ready;
	logic       motor_drive;
	logic [2:0] status;
	logic [7:0] stock_count;
	logic       busy_res;

	modport source (output valid, motor_drive, status, stock_count, busy_res, input ready);
	modport sink   (input valid, motor_drive, status, stock_count, busy_res, output ready);
endinterface

interface dmc_cfg_if import dmc_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/dmc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dmc_cfg_regs
// Configuration register file; always ready, unknown indexes are dropped.
// ----------------------------------------------------------------------------
module dmc_cfg_regs import dmc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dmc_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.relay_inverted      <= RST_RELAY_INV;
			regs_q.low_level_threshold <= RST_LOW_THRESH;
			regs_q.motor_timeout_ms    <= RST_MOTOR_TMO;
			regs_q.remove_timeout_ms   <= RST_REMOVE_TMO;
			regs_q.extra_run_ms        <= RST_EXTRA_RUN;
			regs_q.max_retries         <= RST_MAX_RETRIES;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_RELAY_INV:   regs_q.relay_inverted      <= cfg.data[0];
				CFG_LOW_THRESH:  regs_q.low_level_threshold <= cfg.data[7:0];
				CFG_MOTOR_TMO:   regs_q.motor_timeout_ms    <= cfg.data;
				CFG_REMOVE_TMO:  regs_q.remove_timeout_ms   <= cfg.data;
				CFG_EXTRA_RUN:   regs_q.extra_run_ms        <= cfg.data;
				CFG_MAX_RETRIES: regs_q.max_retries         <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: src/dmc_core.sv
// ----------------------------------------------------------------------------
// dmc_core
// Dispense sequencer: state registers and next-state logic for one tick.
// ----------------------------------------------------------------------------
module dmc_core import dmc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item_s1,
	input  cfg_t    regs,
	output result_t res_d
);

	phase_t      phase_q, phase_d;
	logic [3:0]  attempt_q, attempt_d;
	logic [15:0] timer_q, timer_d;
	logic [7:0]  stock_q, stock_d;
	status_t     status_q, status_d;
	logic [15:0] since_q, since_d;
	logic        pushed;
	logic        blocked;
	logic        motor;
	status_t     query_st;
	logic [16:0] timer_inc;

	assign blocked   = !item_s1.exit_sensor;
	assign timer_inc = {1'b0, timer_q} + 17'd1;

	always_comb begin
		query_st = ST_IDLE;
		if (stock_q < regs.low_level_threshold)
			query_st = ST_LOW;
		if (item_s1.empty_sensor || stock_q == 8'd0)
			query_st = ST_EMPTY;
		if (blocked)
			query_st = (since_q < regs.remove_timeout_ms) ? ST_READY : ST_BLOCKED;
	end

	always_comb begin
		phase_d   = phase_q;
		attempt_d = attempt_q;
		timer_d   = timer_q;
		stock_d   = stock_q;
		status_d  = status_q;
		pushed    = 1'b0;
		unique case (phase_q)
			PH_WAIT: begin
				if (blocked || timer_q >= regs.motor_timeout_ms) begin
					phase_d = PH_EXTRA;
					timer_d = '0;
				end else begin
					timer_d = timer_inc[15:0];
				end
			end
			PH_EXTRA: begin
				if (timer_inc >= {1'b0, regs.extra_run_ms}) begin
					if (blocked) begin
						status_d = ST_READY;
						if (stock_q != 8'd0)
							stock_d = stock_q - 8'd1;
						pushed  = 1'b1;
						phase_d = PH_IDLE;
					end else if (attempt_q < regs.max_retries) begin
						attempt_d = attempt_q + 4'd1;
						phase_d   = PH_WAIT;
					end else begin
						status_d = ST_NOTDISP;
						phase_d  = PH_IDLE;
					end
					timer_d = '0;
				end else begin
					timer_d = timer_inc[15:0];
				end
			end
			default: begin
				phase_d = PH_IDLE;
				unique case (cmd_t'(item_s1.cmd))
					CMD_DISPENSE: begin
						if (item_s1.empty_sensor) begin
							status_d = ST_EMPTY;
						end else if (blocked) begin
							status_d = ST_BLOCKED;
						end else if (status_q == ST_IDLE || status_q == ST_LOW) begin
							status_d  = ST_WORKING;
							attempt_d = '0;
							timer_d   = '0;
							phase_d   = PH_WAIT;
						end
					end
					CMD_QUERY: status_d = query_st;
					CMD_LOAD:  stock_d  = item_s1.stock_value;
					CMD_TICK:  ;
					default:   ;
				endcase
			end
		endcase

		if (pushed)
			since_d = '0;
		else if (since_q != SINCE_SAT)
			since_d = since_q + 16'd1;
		else
			since_d = since_q;
	end

	assign motor = (phase_d != PH_IDLE);

	always_comb begin
		res_d.motor_drive = motor ^ regs.relay_inverted;
		res_d.status      = status_d;
		res_d.stock_count = stock_d;
		res_d.busy_res    = motor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			attempt_q <= '0;
			timer_q   <= '0;
			stock_q   <= '0;
			status_q  <= ST_IDLE;
			since_q   <= SINCE_SAT;
		end else if (step) begin
			phase_q   <= phase_d;
			attempt_q <= attempt_d;
			timer_q   <= timer_d;
			stock_q   <= stock_d;
			status_q  <= status_d;
			since_q   <= since_d;
		end
	end

	a_push_clears_since: assert property (@(posedge clk) disable iff (!arst_n)
		step && pushed |=> since_q == 16'd0)
		else $error("since-push timer not cleared on push");

	a_stock_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_EXTRA && stock_q == 8'd0 |=> stock_q == 8'd0)
		else $error("stock wrapped below zero");

	a_wait_entry_timer: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_d == PH_WAIT && phase_q != PH_WAIT |=> timer_q == 16'd0)
		else $error("phase timer not cleared on attempt start");

	a_busy_status: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_IDLE && phase_d == PH_WAIT |=> status_q == ST_WORKING)
		else $error("dispense started without working status");

endmodule

FILE: src/dispenser_motor_controller.sv
// ----------------------------------------------------------------------------
// dispenser_motor_controller
// Millisecond-tick dispenser sequencer with stock count and status query.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  item     in   cmd, empty_sensor, exit_sensor, stock_value (one tick)
//  result   out  motor_drive, status, stock_count, busy_res (one per tick)
//  cfg      in   index, data (register write, always ready)
//
//  One beat per cycle sustained while results are taken.
//  Input register -> sequencer logic -> result register.
//  Reset: registers at defaults, stock 0, status idle, since-push saturated.
//  A stalled result holds the sequencer; one more item is still taken.
// ----------------------------------------------------------------------------
module dispenser_motor_controller import dmc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	dmc_item_if.sink     item,
	dmc_result_if.source result,
	dmc_cfg_if.sink      cfg
);

	cfg_t    regs;
	item_t   item_s1;
	logic    valid_s1;
	logic    step;
	result_t res_d;
	result_t res_q;
	logic    res_valid_q;

	assign step       = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.cmd          <= item.cmd;
			item_s1.empty_sensor <= item.empty_sensor;
			item_s1.exit_sensor  <= item.exit_sensor;
			item_s1.stock_value  <= item.stock_value;
		end
	end

	dmc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	dmc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item_s1 (item_s1),
		.regs    (regs),
		.res_d   (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res_d;
	end

	assign result.valid       = res_valid_q;
	assign result.motor_drive = res_q.motor_drive;
	assign result.status      = res_q.status;
	assign result.stock_count = res_q.stock_count;
	assign result.busy_res    = res_q.busy_res;

endmodule
